/* src/bsw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ball search watchdog package
// Shared widths, register indexes, reset values and the structs that pass
// between the configuration registers, the core and the top level.
// ----------------------------------------------------------------------------
package bsw_pkg;

    // Solenoids scanned in a pass; only the lowest 32 can ever be enabled.
    localparam int NUM_SOLENOIDS = 32;
    localparam int MASK_W        = 32;
    localparam int SOL_IDX_W     = $clog2(NUM_SOLENOIDS);
    localparam int SOL_CNT_W     = $clog2(NUM_SOLENOIDS + 1);
    localparam int MASK_EXT_W    = (NUM_SOLENOIDS > MASK_W) ? NUM_SOLENOIDS : MASK_W;

    localparam int SECS_W  = 8;
    localparam int DIV_W   = 8;
    localparam int PAUSE_W = 16;
    localparam int SOL_W   = 5;
    localparam int MODE_W  = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_SECS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOLENOID_MASK    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAUSE_SECS       = 2'd3;

    // Register reset values.
    localparam logic [SECS_W-1:0] TIMEOUT_RESET = 8'd10;
    localparam logic [MASK_W-1:0] MASK_RESET    = 32'd0;
    localparam logic [DIV_W-1:0]  TPS_RESET     = 8'd10;
    localparam logic [SECS_W-1:0] PAUSE_RESET   = 8'd15;

    // Word opcodes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_CLOSURE = 1'b1;

    typedef struct packed {
        logic [SECS_W-1:0] timeout_secs;
        logic [MASK_W-1:0] solenoid_mask;
        logic [DIV_W-1:0]  ticks_per_second;
        logic [SECS_W-1:0] pause_secs;
    } cfg_t;

    typedef struct packed {
        logic              pulse_fire;
        logic [SOL_W-1:0]  pulse_solenoid;
        logic [MODE_W-1:0] search_mode;
        logic [SECS_W-1:0] idle_secs;
    } result_t;

endpackage
`default_nettype wire

/* src/bsw_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ball search watchdog configuration registers
// Four write-only registers, loaded by index from the configuration port.
// ----------------------------------------------------------------------------
module bsw_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [bsw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bsw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output bsw_pkg::cfg_t                           cfg
);

    bsw_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_secs     <= bsw_pkg::TIMEOUT_RESET;
            cfg_reg.solenoid_mask    <= bsw_pkg::MASK_RESET;
            cfg_reg.ticks_per_second <= bsw_pkg::TPS_RESET;
            cfg_reg.pause_secs       <= bsw_pkg::PAUSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsw_pkg::CFG_TIMEOUT_SECS:
                    cfg_reg.timeout_secs <= cfg_data[bsw_pkg::SECS_W-1:0];
                bsw_pkg::CFG_SOLENOID_MASK:
                    cfg_reg.solenoid_mask <= cfg_data[bsw_pkg::MASK_W-1:0];
                bsw_pkg::CFG_TICKS_PER_SECOND:
                    cfg_reg.ticks_per_second <= cfg_data[bsw_pkg::DIV_W-1:0];
                bsw_pkg::CFG_PAUSE_SECS:
                    cfg_reg.pause_secs <= cfg_data[bsw_pkg::SECS_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* src/bsw_sol_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ball search watchdog solenoid scanner
// Finds the lowest enabled solenoid at or above a starting number.
// ----------------------------------------------------------------------------
module bsw_sol_scan (
    input  wire logic [bsw_pkg::SOL_CNT_W-1:0] scan_from,
    input  wire logic [bsw_pkg::MASK_W-1:0]    solenoid_mask,
    output logic                               found,
    output logic [bsw_pkg::SOL_IDX_W-1:0]      found_idx
);

    logic [bsw_pkg::MASK_EXT_W-1:0]    mask_ext;
    logic [bsw_pkg::NUM_SOLENOIDS-1:0] cand;

    // Solenoids beyond the mask width read as disabled.
    assign mask_ext = bsw_pkg::MASK_EXT_W'(solenoid_mask);

    always_comb
    begin
        for (int s = 0; s < bsw_pkg::NUM_SOLENOIDS; s++)
        begin
            cand[s] = mask_ext[s] && (bsw_pkg::SOL_CNT_W'(s) >= scan_from);
        end
    end

    always_comb
    begin
        found     = |cand;
        found_idx = '0;
        for (int s = bsw_pkg::NUM_SOLENOIDS - 1; s >= 0; s--)
        begin
            if (cand[s])
            begin
                found_idx = bsw_pkg::SOL_IDX_W'(s);
            end
        end
    end

endmodule
`default_nettype wire

/* src/bsw_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ball search watchdog core
// Idle timer, pass sequencing and pause countdown; one word per step.
// ----------------------------------------------------------------------------
module bsw_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          op,
    input  wire logic          in_game,
    input  wire logic          count_enable,
    input  wire bsw_pkg::cfg_t cfg,
    output bsw_pkg::result_t   res
);

    typedef enum logic [bsw_pkg::MODE_W-1:0] {
        MONITOR = 2'd0,
        SEARCH  = 2'd1,
        PAUSE   = 2'd2
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [bsw_pkg::SECS_W-1:0]        idle_reg, idle_next;
    logic [bsw_pkg::DIV_W-1:0]         div_reg, div_next;
    logic [bsw_pkg::SOL_CNT_W-1:0]     sol_reg, sol_next;
    logic [bsw_pkg::PAUSE_W-1:0]       pause_reg, pause_next;

    logic [bsw_pkg::SOL_CNT_W-1:0]     scan_from;
    logic                              found;
    logic [bsw_pkg::SOL_IDX_W-1:0]     found_idx;
    logic [bsw_pkg::PAUSE_W-1:0]       pause_load;
    logic [bsw_pkg::DIV_W-1:0]         div_inc;
    logic [bsw_pkg::SECS_W-1:0]        idle_inc;
    logic                              fire;
    logic [bsw_pkg::SOL_W-1:0]         sol_out;

    // Only a tick in mid-pass carries on from the saved position.
    assign scan_from = (in_game && (op == bsw_pkg::OP_TICK) && (phase_reg == SEARCH))
                       ? sol_reg : '0;

    bsw_sol_scan u_scan (
        .scan_from     (scan_from),
        .solenoid_mask (cfg.solenoid_mask),
        .found         (found),
        .found_idx     (found_idx)
    );

    assign pause_load = bsw_pkg::PAUSE_W'(cfg.pause_secs) *
                        bsw_pkg::PAUSE_W'(cfg.ticks_per_second);
    assign div_inc    = div_reg + 1'b1;
    assign idle_inc   = (&idle_reg) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        logic do_scan;
        do_scan    = 1'b0;
        phase_next = phase_reg;
        idle_next  = idle_reg;
        div_next   = div_reg;
        sol_next   = sol_reg;
        pause_next = pause_reg;

        if (!in_game)
        begin
            phase_next = MONITOR;
            idle_next  = '0;
            div_next   = '0;
            sol_next   = '0;
            pause_next = '0;
        end
        else if (op == bsw_pkg::OP_CLOSURE)
        begin
            idle_next = '0;
            if (phase_reg == SEARCH)
            begin
                sol_next   = '0;
                phase_next = PAUSE;
                pause_next = pause_load;
            end
        end
        else
        begin
            unique case (phase_reg)
                SEARCH:
                begin
                    do_scan = 1'b1;
                end
                PAUSE:
                begin
                    if (pause_reg <= bsw_pkg::PAUSE_W'(1))
                    begin
                        pause_next = '0;
                        if (idle_reg != '0)
                        begin
                            do_scan = 1'b1;
                        end
                        else
                        begin
                            phase_next = MONITOR;
                            div_next   = '0;
                        end
                    end
                    else
                    begin
                        pause_next = pause_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = MONITOR;
                    div_next   = div_inc;
                    if (div_inc >= cfg.ticks_per_second)
                    begin
                        div_next = '0;
                        if (count_enable)
                        begin
                            idle_next = idle_inc;
                            if (idle_inc >= cfg.timeout_secs)
                            begin
                                do_scan = 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        fire    = 1'b0;
        sol_out = '0;
        if (do_scan)
        begin
            if (found)
            begin
                fire       = 1'b1;
                sol_out    = bsw_pkg::SOL_W'(found_idx);
                sol_next   = bsw_pkg::SOL_CNT_W'(found_idx) + 1'b1;
                phase_next = SEARCH;
            end
            else
            begin
                sol_next   = '0;
                phase_next = PAUSE;
                pause_next = pause_load;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MONITOR;
            idle_reg  <= '0;
            div_reg   <= '0;
            sol_reg   <= '0;
            pause_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idle_reg  <= idle_next;
            div_reg   <= div_next;
            sol_reg   <= sol_next;
            pause_reg <= pause_next;
        end
    end

    assign res.pulse_fire     = fire;
    assign res.pulse_solenoid = sol_out;
    assign res.search_mode    = bsw_pkg::MODE_W'(phase_next);
    assign res.idle_secs      = idle_next;

    a_fire_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        res.pulse_fire |-> (phase_next == SEARCH))
        else $error("pulse issued outside a search pass");

    a_leave_game: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !in_game) |=> (phase_reg == MONITOR && idle_reg == '0 && pause_reg == '0))
        else $error("state not cleared after leaving the game");

    a_pause_only_pausing: assert property (@(posedge clk) disable iff (!rst_n)
        (pause_reg != '0) |-> (phase_reg == PAUSE))
        else $error("pause count held outside the pause");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(idle_reg) && $stable(sol_reg)))
        else $error("state moved without a word");

endmodule
`default_nettype wire

/* src/ball_search_watchdog_unit.sv */
// Path: an accepted word is held in the input register, then passes through
// the core into the result register, from which the receiver takes it.
// Throughput: one word per cycle while out_ready is high; the core updates once per word.
// Reset: rst_n clears both pipeline stages, the watchdog state and loads
// the configuration registers with their defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ball search watchdog unit
// Top level: input and result registers around the watchdog core.
// ----------------------------------------------------------------------------
module ball_search_watchdog_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire logic [bsw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [bsw_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             op,
    input  wire logic                             in_game,
    input  wire logic                             count_enable,

    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  pulse_fire,
    output logic [bsw_pkg::SOL_W-1:0]             pulse_solenoid,
    output logic [bsw_pkg::MODE_W-1:0]            search_mode,
    output logic [bsw_pkg::SECS_W-1:0]            idle_secs
);

    bsw_pkg::cfg_t    cfg;
    bsw_pkg::result_t res;

    // The input stage holds one word; it moves on to the core whenever the
    // result register is empty or its word is being taken in this cycle.
    logic             in_valid_reg;
    logic             op_reg;
    logic             in_game_reg;
    logic             count_enable_reg;
    logic             out_valid_reg;
    bsw_pkg::result_t res_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bsw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The core updates its state on the same edge at which the result
    // of the word is written into the result register.
    bsw_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .op           (op_reg),
        .in_game      (in_game_reg),
        .count_enable (count_enable_reg),
        .cfg          (cfg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg           <= op;
            in_game_reg      <= in_game;
            count_enable_reg <= count_enable;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_fire     = res_reg.pulse_fire;
    assign pulse_solenoid = res_reg.pulse_solenoid;
    assign search_mode    = res_reg.search_mode;
    assign idle_secs      = res_reg.idle_secs;

endmodule
`default_nettype wire

/* tb/sv/ball_search_watchdog_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ball search watchdog unit testbench
// Opens with a short table of directed words and register writes, then runs
// phases of random words under changing register settings. Every result word
// is checked, field by field, against a cycle-free model of the watchdog.
// Both handshakes idle at random, and a long output stall is forced once.
// ----------------------------------------------------------------------------
module ball_search_watchdog_unit_tb;

    import bsw_pkg::*;

    // Give up after this many clock cycles; a correct run needs far fewer.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles of output stall used to back the block up into its input.
    localparam int HOLD_CYCLES = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_MONITOR = 2'd0,
        MODE_SEARCH  = 2'd1,
        MODE_PAUSE   = 2'd2
    } wd_mode_e;

    // One line of the directed table: either a register write or a word,
    // optionally carrying a result that can be read off by eye.
    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   w_op;
        logic                   w_game;
        logic                   w_cnt;
        logic                   typed;
        result_t                res;
    } step_row_t;

    // Register settings and word mix of one random phase.
    typedef struct packed {
        logic [SECS_W-1:0] timeout;
        logic [MASK_W-1:0] mask;
        logic [DIV_W-1:0]  tps;
        logic [SECS_W-1:0] pause;
        logic [15:0]       words;
        logic [7:0]        closure_pct;
        logic [7:0]        noise_pct;
    } phase_cfg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   op;
    logic                   in_game;
    logic                   count_enable;
    logic                   out_valid;
    logic                   out_ready;
    logic                   pulse_fire;
    logic [SOL_W-1:0]       pulse_solenoid;
    logic [MODE_W-1:0]      search_mode;
    logic [SECS_W-1:0]      idle_secs;

    ball_search_watchdog_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .in_game        (in_game),
        .count_enable   (count_enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pulse_fire     (pulse_fire),
        .pulse_solenoid (pulse_solenoid),
        .search_mode    (search_mode),
        .idle_secs      (idle_secs)
    );

    // 4 ns period: high for 2 ns, low for 2 ns.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Watchdog model. These hold the testbench's own copy of the registers
    // and of the state, and are advanced once for every accepted word.
    // ------------------------------------------------------------------------
    logic [SECS_W-1:0]    cf_timeout;
    logic [MASK_W-1:0]    cf_mask;
    logic [DIV_W-1:0]     cf_tps;
    logic [SECS_W-1:0]    cf_pause;

    logic [SECS_W-1:0]    wd_idle;
    logic [DIV_W-1:0]     wd_div;
    wd_mode_e             wd_mode;
    logic [SOL_CNT_W-1:0] wd_next;
    logic [PAUSE_W-1:0]   wd_pause;

    result_t wd_results_q[$];
    int      mismatches;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    logic    hold_req;

    // The pause is reloaded from the product of the two registers.
    task automatic begin_pause();
        wd_mode  = MODE_PAUSE;
        wd_pause = {8'd0, cf_pause} * {8'd0, cf_tps};
    endtask

    // Fire the lowest enabled solenoid not yet pulsed in this pass; when none
    // is left, the pass is over and the pause begins on the same word.
    task automatic scan_solenoids(output logic fired, output logic [SOL_W-1:0] sol);
        int s;
        fired = 1'b0;
        sol   = '0;
        for (s = int'(wd_next); s < NUM_SOLENOIDS && !fired; s++)
        begin
            if (s < MASK_W && cf_mask[s])
            begin
                fired   = 1'b1;
                sol     = s[SOL_W-1:0];
                wd_next = SOL_CNT_W'(s + 1);
            end
        end
        if (!fired)
        begin
            wd_next = '0;
            begin_pause();
        end
    endtask

    task automatic start_search(output logic fired, output logic [SOL_W-1:0] sol);
        wd_mode = MODE_SEARCH;
        wd_next = '0;
        scan_solenoids(fired, sol);
    endtask

    task automatic predict_watchdog(input logic w_op, input logic w_game, input logic w_cnt,
                                    output result_t r);
        logic             fire;
        logic [SOL_W-1:0] sol;
        fire = 1'b0;
        sol  = '0;
        if (!w_game)
        begin
            // Leaving the game drops everything back to its reset state.
            wd_idle  = '0;
            wd_div   = '0;
            wd_mode  = MODE_MONITOR;
            wd_next  = '0;
            wd_pause = '0;
        end
        else if (w_op == OP_CLOSURE)
        begin
            // A closure clears the timer and cuts a running pass short.
            wd_idle = '0;
            if (wd_mode == MODE_SEARCH)
            begin
                wd_next = '0;
                begin_pause();
            end
        end
        else if (wd_mode == MODE_SEARCH)
        begin
            scan_solenoids(fire, sol);
        end
        else if (wd_mode == MODE_PAUSE)
        begin
            if (wd_pause <= 1)
            begin
                wd_pause = '0;
                if (wd_idle != 0)
                begin
                    start_search(fire, sol);
                end
                else
                begin
                    wd_mode = MODE_MONITOR;
                    wd_div  = '0;
                end
            end
            else
            begin
                wd_pause = wd_pause - 1'b1;
            end
        end
        else
        begin
            // Monitoring: a zero divider makes every tick a whole second.
            wd_mode = MODE_MONITOR;
            wd_div  = wd_div + 1'b1;
            if (wd_div >= cf_tps)
            begin
                wd_div = '0;
                if (w_cnt)
                begin
                    if (wd_idle != 8'hFF)
                    begin
                        wd_idle = wd_idle + 1'b1;
                    end
                    if (wd_idle >= cf_timeout)
                    begin
                        start_search(fire, sol);
                    end
                end
            end
        end
        r.pulse_fire     = fire;
        r.pulse_solenoid = fire ? sol : '0;
        r.search_mode    = wd_mode;
        r.idle_secs      = wd_idle;
    endtask

    // ------------------------------------------------------------------------
    // Input side. All driving happens at the falling edge; acceptance is
    // judged from the values seen at the rising edge.
    // ------------------------------------------------------------------------

    // Called at a falling edge, returns at a falling edge after acceptance.
    // Valid stays high after acceptance, so back-to-back words need no gap.
    task automatic offer_word(input logic w_op, input logic w_game, input logic w_cnt,
                              input logic typed, input result_t typed_res);
        result_t r;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        op           = w_op;
        in_game      = w_game;
        count_enable = w_cnt;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_watchdog(w_op, w_game, w_cnt, r);
        wd_results_q.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Holds the input off until every word sent so far has come back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (wd_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Register write on the falling edge; the block is idle by this point.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        case (idx)
            CFG_TIMEOUT_SECS:     cf_timeout = d[SECS_W-1:0];
            CFG_SOLENOID_MASK:    cf_mask    = d[MASK_W-1:0];
            CFG_TICKS_PER_SECOND: cf_tps     = d[DIV_W-1:0];
            default:              cf_pause   = d[SECS_W-1:0];
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic step_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
        step_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = d;
        return row;
    endfunction

    // A word row; typed rows carry the result written out below by hand.
    function automatic step_row_t word_row(input logic w_op, input logic w_game,
                                           input logic w_cnt, input logic typed,
                                           input logic pf, input logic [SOL_W-1:0] ps,
                                           input wd_mode_e md, input logic [SECS_W-1:0] idl);
        step_row_t row;
        row                    = '0;
        row.w_op               = w_op;
        row.w_game             = w_game;
        row.w_cnt              = w_cnt;
        row.typed              = typed;
        row.res.pulse_fire     = pf;
        row.res.pulse_solenoid = ps;
        row.res.search_mode    = md;
        row.res.idle_secs      = idl;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: the ready pattern and the result check.
    // ------------------------------------------------------------------------

    // The receiver draws a new ready each falling edge. When a hold is
    // requested it keeps ready low for a long stretch, counted here, while
    // the sender carries on offering words.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (wd_results_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with none expected, expected none, actual %0h",
                         $time, {pulse_fire, pulse_solenoid, search_mode, idle_secs});
            end
            else
            begin
                want = wd_results_q.pop_front();
                check_field("pulse_fire", 32'(want.pulse_fire), 32'(pulse_fire));
                check_field("pulse_solenoid", 32'(want.pulse_solenoid), 32'(pulse_solenoid));
                check_field("search_mode", 32'(want.search_mode), 32'(search_mode));
                check_field("idle_secs", 32'(want.idle_secs), 32'(idle_secs));
            end
        end
    end

    // Overall time limit for the run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        step_row_t  dir_plan[$];
        phase_cfg_t phases[$];
        phase_cfg_t ph;
        step_row_t  row;
        logic [2:0] bits;
        logic       w_op;
        logic       w_game;
        logic       w_cnt;
        int         i;
        int         n;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = OP_TICK;
        in_game      = 1'b0;
        count_enable = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        snd_idle_pct = 21;
        rcv_idle_pct = 70;

        cf_timeout = TIMEOUT_RESET;
        cf_mask    = MASK_RESET;
        cf_tps     = TPS_RESET;
        cf_pause   = PAUSE_RESET;
        wd_idle    = '0;
        wd_div     = '0;
        wd_mode    = MODE_MONITOR;
        wd_next    = '0;
        wd_pause   = '0;

        // Out of reset, not in game: everything reads as idle.
        dir_plan.push_back(word_row(OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_CLOSURE, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        // Zero timeout, zero divider and zero pause, with only the lowest and
        // the highest solenoid enabled.
        dir_plan.push_back(cfg_row(CFG_TIMEOUT_SECS, 32'd0));
        dir_plan.push_back(cfg_row(CFG_TICKS_PER_SECOND, 32'd0));
        dir_plan.push_back(cfg_row(CFG_SOLENOID_MASK, 32'h8000_0001));
        dir_plan.push_back(cfg_row(CFG_PAUSE_SECS, 32'd0));
        // The first counted second starts a pass and fires on the same word.
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 5'd0, MODE_SEARCH, 8'd1));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 5'd31, MODE_SEARCH, 8'd1));
        // Nothing left to fire: the pass ends and an empty pause begins.
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, MODE_PAUSE, 8'd1));
        // The pause runs out with the timer still set, so a new pass fires.
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 5'd0, MODE_SEARCH, 8'd1));
        // A closure aborts the pass; the pause still has to run.
        dir_plan.push_back(word_row(OP_CLOSURE, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, MODE_PAUSE, 8'd0));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_CLOSURE, 1'b1, 1'b1, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        // Every solenoid enabled, the longest pause, one tick per second.
        dir_plan.push_back(cfg_row(CFG_SOLENOID_MASK, 32'hFFFF_FFFF));
        dir_plan.push_back(cfg_row(CFG_TIMEOUT_SECS, 32'd1));
        dir_plan.push_back(cfg_row(CFG_TICKS_PER_SECOND, 32'd1));
        dir_plan.push_back(cfg_row(CFG_PAUSE_SECS, 32'd255));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 5'd0, MODE_SEARCH, 8'd1));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        // Leaving the game in the middle of a pass.
        dir_plan.push_back(word_row(OP_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_CLOSURE, 1'b1, 1'b0, 1'b1, 1'b0, 5'd0, MODE_PAUSE, 8'd0));
        // Closures and ticks during a pause, then leaving the game from it.
        dir_plan.push_back(word_row(OP_CLOSURE, 1'b1, 1'b1, 1'b0, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0, MODE_MONITOR, 8'd0));
        dir_plan.push_back(word_row(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 5'd0, MODE_MONITOR, 8'd0));

        // Random phases. The long ones with no closures and no noise let the
        // timer climb all the way to 255 and let the longest pause run out.
        phases.push_back('{8'd0, 32'hFFFF_FFFF, 8'd1, 8'd1, 16'd100, 8'd3, 8'd10});
        phases.push_back('{8'd3, $urandom, 8'd2, 8'd2, 16'd100, 8'd3, 8'd10});
        phases.push_back('{8'd255, $urandom, 8'd0, 8'd1, 16'd290, 8'd0, 8'd0});
        phases.push_back('{8'd1, 32'h8000_0000, 8'd1, 8'd255, 16'd290, 8'd0, 8'd0});
        for (i = 0; i < 2; i++)
        begin
            phases.push_back('{8'($urandom_range(5)), $urandom, 8'($urandom_range(4, 1)),
                              8'($urandom_range(3, 1)), 16'd100, 8'd3, 8'd15});
        end
        phases.push_back('{8'd1, $urandom, 8'd255, 8'd1, 16'd60, 8'd2, 8'd5});
        phases.push_back('{8'($urandom_range(4)), $urandom & $urandom, 8'($urandom_range(3, 1)),
                          8'($urandom_range(2, 1)), 16'd100, 8'd4, 8'd20});

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table. Register rows wait for the block to empty first;
        // every word causes a result, so an empty queue means it is idle.
        foreach (dir_plan[k])
        begin
            row = dir_plan[k];
            if (row.is_cfg)
            begin
                wait_drained();
                write_reg(row.idx, row.data);
            end
            else
            begin
                offer_word(row.w_op, row.w_game, row.w_cnt, row.typed, row.res);
            end
        end

        foreach (phases[p])
        begin
            ph = phases[p];
            if (p < 3)
            begin
                snd_idle_pct = 21;
                rcv_idle_pct = 70;
            end
            else if (p < 6)
            begin
                snd_idle_pct = 70;
                rcv_idle_pct = 21;
            end
            else
            begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            wait_drained();
            write_reg(CFG_TIMEOUT_SECS, 32'(ph.timeout));
            write_reg(CFG_SOLENOID_MASK, ph.mask);
            write_reg(CFG_TICKS_PER_SECOND, 32'(ph.tps));
            write_reg(CFG_PAUSE_SECS, 32'(ph.pause));

            // Stall the output for a long stretch early in one phase, so the
            // pipeline fills and in_ready drops while words keep coming.
            if (p == 1)
            begin
                hold_req = 1'b1;
            end

            n = int'(ph.words);
            for (i = 0; i < n; i++)
            begin
                // Once, halfway through a phase, the sender waits for every
                // outstanding result before it carries on.
                if (p == 4 && i == n / 2)
                begin
                    wait_drained();
                end
                if ($urandom_range(99) < int'(ph.noise_pct))
                begin
                    bits   = 3'($urandom_range(7));
                    w_op   = bits[0];
                    w_game = bits[1];
                    w_cnt  = bits[2];
                end
                else
                begin
                    w_op   = ($urandom_range(99) < int'(ph.closure_pct)) ? OP_CLOSURE : OP_TICK;
                    w_game = 1'b1;
                    w_cnt  = ($urandom_range(9) != 0);
                end
                offer_word(w_op, w_game, w_cnt, 1'b0, '0);
            end
        end

        // Let every result come back, then wait on for anything stray
        // from the two-stage pipeline.
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
